@@ src/bpps_pkg.sv @@
// shared types and constants for the blinn-phong point shader
// used by the channel interfaces, the controller, the datapath and the top level
package bpps_pkg;

  // field widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned NORM_W  = 16;
  localparam int unsigned POWER_W = 16;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned LEVEL_W = 24;
  localparam int unsigned COUNT_W = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHTS_IN_USE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_LEVEL = 3'd4;

  // register reset values
  localparam logic signed [COORD_W-1:0] VIEW_X_RST  = 16'sd0;
  localparam logic signed [COORD_W-1:0] VIEW_Y_RST  = 16'sd0;
  localparam logic signed [COORD_W-1:0] VIEW_Z_RST  = 16'sd768;
  localparam logic [COUNT_W-1:0]        LIGHTS_RST  = 4'd0;
  localparam logic [CFG_DATA_W-1:0]     AMBIENT_RST = 16'd12800;

  // parameter defaults
  localparam int unsigned DEF_MAX_LIGHTS      = 8;
  localparam int unsigned DEF_COORD_FRAC_BITS = 8;

  // arithmetic constants
  localparam logic [LEVEL_W-1:0] OUT_MAX  = 24'hFF_FFFF;
  localparam logic [32:0]        ATT_CAP  = 33'h1_0000_0000;
  localparam logic [14:0]        ONE_Q14  = 15'd16384;
  localparam logic [16:0]        KS_Q16   = 17'd52429;
  localparam int unsigned        POW_LAST = 13;

  // step selects
  localparam logic [3:0] SUM_STEP_LAST = 4'd3;
  localparam logic [3:0] COMP_LAST     = 4'd2;
  localparam logic [3:0] DIV_SEL_ATT   = 4'd3;

  typedef enum logic [5:0] {
    ST_IDLE, ST_SETUP, ST_SQ, ST_CHK, ST_ZERO,
    ST_ATT_DIV, ST_ATT_WAIT, ST_ATT_STORE,
    ST_SQRT, ST_SQRT_WAIT, ST_DIV, ST_DIV_WAIT, ST_DIV_STORE,
    ST_SAVE_VIEW, ST_RD, ST_LD, ST_SAVE_L, ST_SAVE_H,
    ST_DOT_L, ST_CLAMP_L, ST_DOT_H, ST_CLAMP_H,
    ST_POW_MUL, ST_POW_SHIFT, ST_DIFF_MUL, ST_DIFF_ADD,
    ST_SPEC_MUL, ST_SPEC_X, ST_SPEC_LO, ST_SPEC_HI, ST_SPEC_ADD,
    ST_NEXT, ST_FIN
  } ctrl_state_t;

  typedef enum logic [1:0] {
    PH_VIEW, PH_LIGHT, PH_HALF
  } phase_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_VIEW_SETUP, OP_SQ, OP_ZERO_UNIT,
    OP_DIV_START, OP_DIV_STORE, OP_SQRT_START,
    OP_SAVE_VIEW, OP_RD, OP_LD_LIGHT, OP_SAVE_L, OP_SAVE_H,
    OP_DOT_L, OP_DOT_H, OP_CLAMP_L, OP_CLAMP_H,
    OP_POW_MUL, OP_POW_SHIFT, OP_DIFF_MUL, OP_DIFF_ADD,
    OP_SPEC_MUL, OP_SPEC_X, OP_SPEC_LO, OP_SPEC_HI, OP_SPEC_ADD,
    OP_NEXT, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [3:0] step;
    logic       take;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic in_shade;
    logic acc_zero;
    logic div_busy;
    logic sqrt_busy;
    logic no_lights;
    logic last_light;
    logic out_free;
  } dp_stat_t;

endpackage

@@ src/bpps_if.sv @@
// valid/ready channel interfaces for shade requests and shade results
// depends on bpps_pkg for field widths
interface bpps_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    cmd;
  logic [bpps_pkg::SLOT_W-1:0]             light_slot;
  logic signed [bpps_pkg::COORD_W-1:0]     lamp_x;
  logic signed [bpps_pkg::COORD_W-1:0]     lamp_y;
  logic signed [bpps_pkg::COORD_W-1:0]     lamp_z;
  logic [bpps_pkg::POWER_W-1:0]            lamp_power;
  logic signed [bpps_pkg::COORD_W-1:0]     point_x;
  logic signed [bpps_pkg::COORD_W-1:0]     point_y;
  logic signed [bpps_pkg::COORD_W-1:0]     point_z;
  logic signed [bpps_pkg::NORM_W-1:0]      normal_x;
  logic signed [bpps_pkg::NORM_W-1:0]      normal_y;
  logic signed [bpps_pkg::NORM_W-1:0]      normal_z;

  modport source (output valid, cmd, light_slot, lamp_x, lamp_y, lamp_z, lamp_power,
                  point_x, point_y, point_z, normal_x, normal_y, normal_z,
                  input ready);
  modport sink   (input valid, cmd, light_slot, lamp_x, lamp_y, lamp_z, lamp_power,
                  point_x, point_y, point_z, normal_x, normal_y, normal_z,
                  output ready);
endinterface

interface bpps_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpps_pkg::LEVEL_W-1:0]  shade_level;
  logic                          clipped;

  modport source (output valid, shade_level, clipped, input ready);
  modport sink   (input valid, shade_level, clipped, output ready);
endinterface

@@ src/bpps_ctrl.sv @@
// sequencing state machine of the shader: walks normalizations, lights and sums
// depends on bpps_pkg for the state, command and status types
module bpps_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  bpps_pkg::dp_stat_t stat,
  output bpps_pkg::dp_cmd_t  cmd
);
  import bpps_pkg::*;

  ctrl_state_t state, state_next;
  phase_t      phase, phase_next;
  logic [3:0]  step, step_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_VIEW;
      step  <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      step  <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    phase_next = phase;
    step_next  = step;
    cmd.op     = OP_NONE;
    cmd.step   = step;
    cmd.take   = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (stat.in_valid && stat.in_shade) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.op     = OP_VIEW_SETUP;
        phase_next = PH_VIEW;
        step_next  = '0;
        state_next = ST_SQ;
      end
      // sum of squares over three components
      ST_SQ: begin
        cmd.op = OP_SQ;
        if (step == SUM_STEP_LAST) begin
          step_next  = '0;
          state_next = ST_CHK;
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_CHK: begin
        if (stat.acc_zero) begin
          state_next = (phase == PH_LIGHT) ? ST_NEXT : ST_ZERO;
        end else begin
          state_next = (phase == PH_LIGHT) ? ST_ATT_DIV : ST_SQRT;
        end
      end
      ST_ZERO: begin
        cmd.op     = OP_ZERO_UNIT;
        state_next = (phase == PH_VIEW) ? ST_SAVE_VIEW : ST_SAVE_H;
      end
      // attenuation divide
      ST_ATT_DIV: begin
        cmd.op     = OP_DIV_START;
        cmd.step   = DIV_SEL_ATT;
        state_next = ST_ATT_WAIT;
      end
      ST_ATT_WAIT: begin
        if (!stat.div_busy) state_next = ST_ATT_STORE;
      end
      ST_ATT_STORE: begin
        cmd.op     = OP_DIV_STORE;
        cmd.step   = DIV_SEL_ATT;
        state_next = ST_SQRT;
      end
      // vector length then one divide per component
      ST_SQRT: begin
        cmd.op     = OP_SQRT_START;
        state_next = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (!stat.sqrt_busy) begin
          step_next  = '0;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.op     = OP_DIV_START;
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat.div_busy) state_next = ST_DIV_STORE;
      end
      ST_DIV_STORE: begin
        cmd.op = OP_DIV_STORE;
        if (step == COMP_LAST) begin
          step_next = '0;
          case (phase)
            PH_VIEW:  state_next = ST_SAVE_VIEW;
            PH_LIGHT: state_next = ST_SAVE_L;
            default:  state_next = ST_SAVE_H;
          endcase
        end else begin
          step_next  = step + 4'd1;
          state_next = ST_DIV;
        end
      end
      ST_SAVE_VIEW: begin
        cmd.op     = OP_SAVE_VIEW;
        state_next = stat.no_lights ? ST_FIN : ST_RD;
      end
      // light loop
      ST_RD: begin
        cmd.op     = OP_RD;
        state_next = ST_LD;
      end
      ST_LD: begin
        cmd.op     = OP_LD_LIGHT;
        phase_next = PH_LIGHT;
        step_next  = '0;
        state_next = ST_SQ;
      end
      ST_SAVE_L: begin
        cmd.op     = OP_SAVE_L;
        phase_next = PH_HALF;
        step_next  = '0;
        state_next = ST_SQ;
      end
      ST_SAVE_H: begin
        cmd.op     = OP_SAVE_H;
        step_next  = '0;
        state_next = ST_DOT_L;
      end
      ST_DOT_L: begin
        cmd.op = OP_DOT_L;
        if (step == SUM_STEP_LAST) begin
          step_next  = '0;
          state_next = ST_CLAMP_L;
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_CLAMP_L: begin
        cmd.op     = OP_CLAMP_L;
        state_next = ST_DOT_H;
      end
      ST_DOT_H: begin
        cmd.op = OP_DOT_H;
        if (step == SUM_STEP_LAST) begin
          step_next  = '0;
          state_next = ST_CLAMP_H;
        end else begin
          step_next = step + 4'd1;
        end
      end
      ST_CLAMP_H: begin
        cmd.op     = OP_CLAMP_H;
        step_next  = '0;
        state_next = ST_POW_MUL;
      end
      // fifteenth power by repeated multiply
      ST_POW_MUL: begin
        cmd.op     = OP_POW_MUL;
        state_next = ST_POW_SHIFT;
      end
      ST_POW_SHIFT: begin
        cmd.op = OP_POW_SHIFT;
        if (step == 4'(POW_LAST)) begin
          step_next  = '0;
          state_next = ST_DIFF_MUL;
        end else begin
          step_next  = step + 4'd1;
          state_next = ST_POW_MUL;
        end
      end
      ST_DIFF_MUL: begin
        cmd.op     = OP_DIFF_MUL;
        state_next = ST_DIFF_ADD;
      end
      ST_DIFF_ADD: begin
        cmd.op     = OP_DIFF_ADD;
        state_next = ST_SPEC_MUL;
      end
      ST_SPEC_MUL: begin
        cmd.op     = OP_SPEC_MUL;
        state_next = ST_SPEC_X;
      end
      ST_SPEC_X: begin
        cmd.op     = OP_SPEC_X;
        state_next = ST_SPEC_LO;
      end
      ST_SPEC_LO: begin
        cmd.op     = OP_SPEC_LO;
        state_next = ST_SPEC_HI;
      end
      ST_SPEC_HI: begin
        cmd.op     = OP_SPEC_HI;
        state_next = ST_SPEC_ADD;
      end
      ST_SPEC_ADD: begin
        cmd.op     = OP_SPEC_ADD;
        state_next = ST_NEXT;
      end
      ST_NEXT: begin
        cmd.op     = OP_NEXT;
        state_next = stat.last_light ? ST_FIN : ST_RD;
      end
      // hand the sum to the output register
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.op     = OP_FINISH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ src/bpps_dp.sv @@
// shader datapath: config registers, light memory, shared multiplier, divider, square root
// depends on bpps_pkg and the channel interfaces in bpps_if
module bpps_dp #(
  parameter int unsigned MAX_LIGHTS      = bpps_pkg::DEF_MAX_LIGHTS,
  parameter int unsigned COORD_FRAC_BITS = bpps_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  bpps_pkg::dp_cmd_t                   cmd,
  output bpps_pkg::dp_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [bpps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpps_pkg::CFG_DATA_W-1:0]     cfg_data,
  bpps_in_if.sink                             req,
  bpps_out_if.source                          rsp
);
  import bpps_pkg::*;

  localparam int unsigned AW      = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int unsigned ATT_SH  = 2 * COORD_FRAC_BITS + 8;
  localparam int unsigned DIVW    = (ATT_SH + 16 > 46) ? ATT_SH + 16 : 46;
  localparam int unsigned DCW     = $clog2(DIVW + 1);
  localparam int unsigned CNT_CAP = (MAX_LIGHTS < 15) ? MAX_LIGHTS : 15;

  // configuration registers
  logic signed [COORD_W-1:0] view_x, view_y, view_z;
  logic [COUNT_W-1:0]        lights_in_use;
  logic [CFG_DATA_W-1:0]     ambient_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_x        <= VIEW_X_RST;
      view_y        <= VIEW_Y_RST;
      view_z        <= VIEW_Z_RST;
      lights_in_use <= LIGHTS_RST;
      ambient_level <= AMBIENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_VIEW_X:        view_x        <= cfg_data;
        CFG_VIEW_Y:        view_y        <= cfg_data;
        CFG_VIEW_Z:        view_z        <= cfg_data;
        CFG_LIGHTS_IN_USE: lights_in_use <= cfg_data[COUNT_W-1:0];
        CFG_AMBIENT_LEVEL: ambient_level <= cfg_data;
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept    = cmd.take && req.valid;
  assign req.ready = cmd.take;

  // light memory, written by light transactions, read at the light index
  logic [63:0]         lamp_mem [MAX_LIGHTS];
  logic [63:0]         rd_q;
  logic [AW-1:0]       waddr, raddr;
  logic [COUNT_W-1:0]  k;
  logic [COUNT_W-1:0]  count;

  assign waddr = AW'(req.light_slot);
  assign raddr = AW'(k);
  assign count = (32'(lights_in_use) > CNT_CAP) ? COUNT_W'(CNT_CAP) : lights_in_use;

  always_ff @(posedge clk) begin
    if (accept && !req.cmd && (32'(req.light_slot) < MAX_LIGHTS)) begin
      lamp_mem[waddr] <= {req.lamp_x, req.lamp_y, req.lamp_z, req.lamp_power};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RD) rd_q <= lamp_mem[raddr];
  end

  // working registers
  logic signed [COORD_W-1:0] px [3];
  logic signed [NORM_W-1:0]  nrm [3];
  logic signed [17:0]        vec [3];
  logic signed [17:0]        uvec [3];
  logic signed [17:0]        vw [3];
  logic signed [17:0]        lv [3];
  logic signed [17:0]        hv [3];
  logic signed [36:0]        acc;
  logic signed [52:0]        prod;
  logic [POWER_W-1:0]        lamp_pow;
  logic [32:0]               att;
  logic [14:0]               nl, nh, np;
  logic [46:0]               xs;
  logic [34:0]               lo_part;
  logic [LEVEL_W-1:0]        sum;
  logic                      clip;
  logic                      out_valid;
  logic [LEVEL_W-1:0]        out_level;
  logic                      out_clip;

  logic [1:0] ix;
  assign ix = (cmd.step[1:0] == 2'd3) ? 2'd0 : cmd.step[1:0];

  // shared multiplier operand select
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ: begin
        mul_a = 35'(vec[ix]);
        mul_b = vec[ix];
      end
      OP_DOT_L: begin
        mul_a = 35'(nrm[ix]);
        mul_b = lv[ix];
      end
      OP_DOT_H: begin
        mul_a = 35'(nrm[ix]);
        mul_b = hv[ix];
      end
      OP_POW_MUL: begin
        mul_a = 35'(np);
        mul_b = 18'(nh);
      end
      OP_DIFF_MUL: begin
        mul_a = 35'(att);
        mul_b = 18'(nl);
      end
      OP_SPEC_MUL: begin
        mul_a = 35'(att);
        mul_b = 18'(np);
      end
      OP_SPEC_LO: begin
        mul_a = 35'(xs[16:0]);
        mul_b = 18'(KS_Q16);
      end
      OP_SPEC_HI: begin
        mul_a = 35'(xs[46:17]);
        mul_b = 18'(KS_Q16);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // radix-2 restoring divider, one quotient bit per cycle
  logic [DIVW-1:0] dv_num;
  logic [36:0]     dv_rem, dv_den;
  logic [DCW-1:0]  dv_cnt;
  logic [37:0]     dv_trial;
  logic            dv_ge;
  logic [17:0]     vmag;
  logic [32:0]     len;

  assign vmag     = vec[ix][17] ? 18'(-vec[ix]) : 18'(vec[ix]);
  assign dv_trial = {dv_rem, dv_num[DIVW-1]};
  assign dv_ge    = dv_trial >= {1'b0, dv_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_cnt <= '0;
    end else if (cmd.op == OP_DIV_START) begin
      dv_cnt <= DCW'(DIVW);
      dv_rem <= '0;
      if (cmd.step == DIV_SEL_ATT) begin
        dv_num <= DIVW'(lamp_pow) << ATT_SH;
        dv_den <= 37'(acc);
      end else begin
        dv_num <= DIVW'(vmag) << 28;
        dv_den <= 37'(len);
      end
    end else if (dv_cnt != '0) begin
      dv_cnt <= dv_cnt - 1'b1;
      dv_rem <= dv_ge ? 37'(dv_trial - {1'b0, dv_den}) : dv_trial[36:0];
      dv_num <= {dv_num[DIVW-2:0], dv_ge};
    end
  end

  // bitwise integer square root, two radicand bits per cycle
  logic [63:0] sq_v, sq_res, sq_bit, sq_trial;
  logic [5:0]  sq_cnt;

  assign sq_trial = sq_res + sq_bit;
  assign len      = sq_res[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_cnt <= '0;
    end else if (cmd.op == OP_SQRT_START) begin
      sq_cnt <= 6'd32;
      sq_v   <= 64'(acc[35:0]) << 28;
      sq_res <= '0;
      sq_bit <= 64'h4000_0000_0000_0000;
    end else if (sq_cnt != '0) begin
      sq_cnt <= sq_cnt - 6'd1;
      sq_bit <= sq_bit >> 2;
      if (sq_v >= sq_trial) begin
        sq_v   <= sq_v - sq_trial;
        sq_res <= (sq_res >> 1) + sq_bit;
      end else begin
        sq_res <= sq_res >> 1;
      end
    end
  end

  // saturating add into the running sum, top bit is the clip flag
  function automatic logic [LEVEL_W:0] add_sat(input logic [LEVEL_W-1:0] s,
                                               input logic [33:0] t);
    logic [34:0] w;
    w = 35'(s) + 35'(t);
    if (w > 35'(OUT_MAX)) add_sat = {1'b1, OUT_MAX};
    else                  add_sat = {1'b0, w[LEVEL_W-1:0]};
  endfunction

  // clamped dot product from the accumulator
  logic [14:0] dot_c;
  always_comb begin
    if (acc <= 0)                  dot_c = '0;
    else if (acc[36:14] > 23'(ONE_Q14)) dot_c = ONE_Q14;
    else                           dot_c = acc[28:14];
  end

  logic [63:0]        spec_full;
  logic [LEVEL_W:0]   diff_sum, spec_sum;
  logic [DIVW-1:0]    quo;
  logic [17:0]        qs;

  assign spec_full = {prod[46:0], 17'b0} + 64'(lo_part);
  assign diff_sum  = add_sat(sum, 34'(prod[46:15]));
  assign spec_sum  = add_sat(sum, spec_full[63:30]);
  assign quo       = dv_num;
  assign qs        = quo[17:0];

  // datapath register updates
  always_ff @(posedge clk) begin
    if (accept && req.cmd) begin
      px[0]  <= req.point_x;
      px[1]  <= req.point_y;
      px[2]  <= req.point_z;
      nrm[0] <= req.normal_x;
      nrm[1] <= req.normal_y;
      nrm[2] <= req.normal_z;
    end
    case (cmd.op)
      OP_VIEW_SETUP: begin
        vec[0] <= 18'(view_x) - 18'(px[0]);
        vec[1] <= 18'(view_y) - 18'(px[1]);
        vec[2] <= 18'(view_z) - 18'(px[2]);
        sum    <= LEVEL_W'(ambient_level);
        clip   <= 1'b0;
      end
      OP_SQ, OP_DOT_L, OP_DOT_H: begin
        if (cmd.step == '0) acc <= '0;
        else                acc <= acc + 37'(prod);
      end
      OP_ZERO_UNIT: begin
        for (int i = 0; i < 3; i++) uvec[i] <= '0;
      end
      OP_DIV_STORE: begin
        if (cmd.step == DIV_SEL_ATT) begin
          att <= (quo > DIVW'(ATT_CAP)) ? ATT_CAP : quo[32:0];
        end else begin
          uvec[ix] <= vec[ix][17] ? -$signed(qs) : $signed(qs);
        end
      end
      OP_SAVE_VIEW: begin
        for (int i = 0; i < 3; i++) vw[i] <= uvec[i];
        k <= '0;
      end
      OP_LD_LIGHT: begin
        vec[0]   <= 18'($signed(rd_q[63:48])) - 18'(px[0]);
        vec[1]   <= 18'($signed(rd_q[47:32])) - 18'(px[1]);
        vec[2]   <= 18'($signed(rd_q[31:16])) - 18'(px[2]);
        lamp_pow <= rd_q[15:0];
      end
      OP_SAVE_L: begin
        for (int i = 0; i < 3; i++) begin
          lv[i]  <= uvec[i];
          vec[i] <= uvec[i] + vw[i];
        end
      end
      OP_SAVE_H: begin
        for (int i = 0; i < 3; i++) hv[i] <= uvec[i];
      end
      OP_CLAMP_L: nl <= dot_c;
      OP_CLAMP_H: begin
        nh <= dot_c;
        np <= dot_c;
      end
      OP_POW_SHIFT: np <= prod[28:14];
      OP_DIFF_ADD: begin
        sum  <= diff_sum[LEVEL_W-1:0];
        clip <= clip | diff_sum[LEVEL_W];
      end
      OP_SPEC_X:  xs <= prod[46:0];
      OP_SPEC_HI: lo_part <= prod[34:0];
      OP_SPEC_ADD: begin
        sum  <= spec_sum[LEVEL_W-1:0];
        clip <= clip | spec_sum[LEVEL_W];
      end
      OP_NEXT: k <= k + 1'b1;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_FINISH) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_FINISH) begin
      out_level <= sum;
      out_clip  <= clip;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.shade_level = out_level;
  assign rsp.clipped     = out_clip;

  // status to the controller
  assign stat.in_valid   = req.valid;
  assign stat.in_shade   = req.cmd;
  assign stat.acc_zero   = (acc == '0);
  assign stat.div_busy   = (dv_cnt != '0);
  assign stat.sqrt_busy  = (sq_cnt != '0);
  assign stat.no_lights  = (count == '0);
  assign stat.last_light = (k == count - 1'b1);
  assign stat.out_free   = !out_valid || rsp.ready;

  // a sum of squares never comes out negative
  a_sq_nonneg: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SQ && cmd.step == SUM_STEP_LAST) |=> !acc[36])
    else $error("sum of squares negative");

  // shared units are only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_START) |-> (dv_cnt == '0))
    else $error("divider restarted while busy");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_SQRT_START) |-> (sq_cnt == '0))
    else $error("square root restarted while busy");

  // attenuation stays within its cap
  a_att_cap: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DIV_STORE && cmd.step == DIV_SEL_ATT) |=> (att <= ATT_CAP))
    else $error("attenuation above cap");

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_FINISH) |-> (!out_valid || rsp.ready))
    else $error("result overwritten");

endmodule

@@ src/blinn_phong_point_shader.sv @@
// Grey Blinn-Phong shader for one surface point against a table of up to MAX_LIGHTS point
// lights. A transaction with cmd 0 stores one light entry and gives no result; a transaction
// with cmd 1 shades a point and gives one result. Items are worked one at a time: a shade
// runs through the N lights in use (N clamped to the table size) on the shared radix-2
// divider, which takes one quotient bit per cycle and runs up to seven divisions per light,
// and on the square root unit, which runs up to two square roots per light. A finished
// result waits in the output register while the next transaction is taken. Light entries
// read before they are written give undefined results.
// depends on bpps_pkg, bpps_if, bpps_ctrl and bpps_dp
module blinn_phong_point_shader #(
  parameter int unsigned MAX_LIGHTS      = bpps_pkg::DEF_MAX_LIGHTS,
  parameter int unsigned COORD_FRAC_BITS = bpps_pkg::DEF_COORD_FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bpps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bpps_pkg::CFG_DATA_W-1:0] cfg_data,
  bpps_in_if.sink                         shade_req,
  bpps_out_if.source                      shade_rsp
);
  import bpps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bpps_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // arithmetic and storage
  bpps_dp #(
    .MAX_LIGHTS      (MAX_LIGHTS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (shade_req),
    .rsp       (shade_rsp)
  );

endmodule

@@ tb/tb_blinn_phong_point_shader.sv @@
// self-checking testbench for blinn_phong_point_shader: directed table, then random phases
// depends on bpps_pkg, bpps_if and the blinn_phong_point_shader rtl
`timescale 1ns / 1ps
module tb_blinn_phong_point_shader;
  import bpps_pkg::*;

  localparam bit CMD_WRITE = 1'b0;
  localparam bit CMD_SHADE = 1'b1;
  localparam int NUM_SLOTS = 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 6000;

  typedef struct {
    bit                 cmd;
    logic [SLOT_W-1:0]  slot;
    logic [15:0]        lx, ly, lz, pw;
    logic [15:0]        px, py, pz, nx, ny, nz;
  } req_t;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    bit                 clip;
  } shade_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    req_t                req;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]         val;
    bit                  has_exp;
    shade_t              exp_shade;
  } row_t;

  typedef longint signed vec3_t[3];

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bpps_in_if  shade_req ();
  bpps_out_if shade_rsp ();

  blinn_phong_point_shader dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .shade_req(shade_req), .shade_rsp(shade_rsp)
  );

  // shadow copy of registers and light table
  longint signed   eye[3];
  int unsigned     lamps_used;
  longint unsigned ambient;
  longint signed   lamp_pos[NUM_SLOTS][3];
  longint unsigned lamp_pw[NUM_SLOTS];

  shade_t shade_expected_q[$];
  row_t   dir_rows[$];
  int     mismatches, shades_seen, writes_sent, clipped_seen;
  int     snd_idle_pct, rcv_idle_pct, phase_no;
  int     hold_left;
  bit     hold_done;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #300_000_000;
    $display("blinn_phong_point_shader: mismatch");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(longint signed a);
    return a < 0 ? longint'(-a) : longint'(a);
  endfunction

  // q2.14 unit vector, zero vector stays zero
  function automatic void to_unit(input vec3_t a, output vec3_t o);
    longint unsigned s2, len, q;
    s2 = 0;
    for (int i = 0; i < 3; i++) s2 += mag(a[i]) * mag(a[i]);
    if (s2 == 0) begin
      o[0] = 0; o[1] = 0; o[2] = 0;
    end else begin
      len = int_sqrt(s2 << 28);
      for (int i = 0; i < 3; i++) begin
        q = (mag(a[i]) << 28) / len;
        o[i] = a[i] < 0 ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic longint unsigned dot_clamped(vec3_t n, vec3_t u);
    longint signed d;
    longint unsigned r;
    d = n[0] * u[0] + n[1] * u[1] + n[2] * u[2];
    if (d <= 0) return 0;
    r = longint'(d) >> 14;
    return r > 16384 ? 16384 : r;
  endfunction

  function automatic shade_t shade_point(req_t r);
    vec3_t p, n, vd, v, d, l, hs, h;
    longint unsigned sum, r2, att, nl, nh, np;
    int unsigned cnt;
    shade_t s;
    s.clip = 1'b0;
    p[0] = longint'($signed(r.px)); p[1] = longint'($signed(r.py));
    p[2] = longint'($signed(r.pz));
    n[0] = longint'($signed(r.nx)); n[1] = longint'($signed(r.ny));
    n[2] = longint'($signed(r.nz));
    for (int i = 0; i < 3; i++) vd[i] = eye[i] - p[i];
    to_unit(vd, v);
    sum = ambient;
    cnt = lamps_used < NUM_SLOTS ? lamps_used : NUM_SLOTS;
    for (int k = 0; k < cnt; k++) begin
      r2 = 0;
      for (int i = 0; i < 3; i++) begin
        d[i] = lamp_pos[k][i] - p[i];
        r2 += mag(d[i]) * mag(d[i]);
      end
      // light sitting on the point is skipped
      if (r2 == 0) continue;
      att = (lamp_pw[k] << 24) / r2;
      if (att > 64'h1_0000_0000) att = 64'h1_0000_0000;
      to_unit(d, l);
      for (int i = 0; i < 3; i++) hs[i] = l[i] + v[i];
      to_unit(hs, h);
      nl = dot_clamped(n, l);
      nh = dot_clamped(n, h);
      np = nh;
      for (int i = 0; i < 14; i++) np = (np * nh) >> 14;
      sum += (att * nl) >> 15;
      if (sum > 64'hFF_FFFF) begin sum = 64'hFF_FFFF; s.clip = 1'b1; end
      sum += (att * np * 52429) >> 30;
      if (sum > 64'hFF_FFFF) begin sum = 64'hFF_FFFF; s.clip = 1'b1; end
    end
    s.level = sum[LEVEL_W-1:0];
    return s;
  endfunction

  // table rows
  function automatic void add_write(int slot, int x, int y, int z, int pw);
    row_t w;
    w = '{kind: ROW_ITEM, default: '0};
    w.req.cmd = CMD_WRITE;
    w.req.slot = SLOT_W'(slot);
    w.req.lx = 16'(x); w.req.ly = 16'(y); w.req.lz = 16'(z); w.req.pw = 16'(pw);
    dir_rows = {dir_rows, w};
  endfunction

  function automatic void add_shade(int x, int y, int z, int nx, int ny, int nz,
                                    bit has, int lvl, bit clp);
    row_t w;
    w = '{kind: ROW_ITEM, default: '0};
    w.req.cmd = CMD_SHADE;
    w.req.px = 16'(x); w.req.py = 16'(y); w.req.pz = 16'(z);
    w.req.nx = 16'(nx); w.req.ny = 16'(ny); w.req.nz = 16'(nz);
    w.has_exp = has;
    w.exp_shade.level = LEVEL_W'(lvl);
    w.exp_shade.clip = clp;
    dir_rows = {dir_rows, w};
  endfunction

  function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    row_t w;
    w = '{kind: ROW_CFG, default: '0};
    w.idx = idx;
    w.val = 16'(val);
    dir_rows = {dir_rows, w};
  endfunction

  // register write into the block and the shadow copy; caller lowers cfg_we
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_VIEW_X:        eye[0] = longint'($signed(val));
      CFG_VIEW_Y:        eye[1] = longint'($signed(val));
      CFG_VIEW_Z:        eye[2] = longint'($signed(val));
      CFG_LIGHTS_IN_USE: lamps_used = 32'(val[COUNT_W-1:0]);
      CFG_AMBIENT_LEVEL: ambient = 64'(val);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // wait until every shade result is back and the block is idle
  task automatic drain();
    shade_req.valid <= 1'b0;
    while (shade_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send(req_t r, bit has_exp, shade_t exp_shade);
    shade_t e;
    if (snd_idle_pct > 0 && $urandom_range(99) < snd_idle_pct) begin
      shade_req.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    shade_req.valid <= 1'b1;
    shade_req.cmd <= r.cmd;
    shade_req.light_slot <= r.slot;
    shade_req.lamp_x <= r.lx; shade_req.lamp_y <= r.ly; shade_req.lamp_z <= r.lz;
    shade_req.lamp_power <= r.pw;
    shade_req.point_x <= r.px; shade_req.point_y <= r.py; shade_req.point_z <= r.pz;
    shade_req.normal_x <= r.nx; shade_req.normal_y <= r.ny; shade_req.normal_z <= r.nz;
    do @(posedge clk); while (!shade_req.ready);
    if (r.cmd == CMD_WRITE) begin
      lamp_pos[r.slot][0] = longint'($signed(r.lx));
      lamp_pos[r.slot][1] = longint'($signed(r.ly));
      lamp_pos[r.slot][2] = longint'($signed(r.lz));
      lamp_pw[r.slot] = 64'(r.pw);
      writes_sent++;
    end else begin
      e = has_exp ? exp_shade : shade_point(r);
      shade_expected_q = {shade_expected_q, e};
    end
  endtask

  // coordinates: extremes, anything, or clustered near the origin
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(2047)) - 16'd1024;
    endcase
  endfunction

  function automatic logic [15:0] pick_normal();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'd16384 : -16'sd16384;
      1:       return 16'($urandom);
      default: return 16'($urandom_range(32768)) - 16'd16384;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    shade_t e;
    if (!rst && shade_rsp.valid && shade_rsp.ready) begin
      shades_seen++;
      if (shade_rsp.clipped) clipped_seen++;
      if (shade_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result level=%0d clipped=%0b", shade_rsp.shade_level,
                   shade_rsp.clipped);
      end else begin
        e = shade_expected_q.pop_front();
        if (shade_rsp.shade_level !== e.level || shade_rsp.clipped !== e.clip) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: expected level=%0d clipped=%0b, got level=%0d clipped=%0b",
                     shades_seen, e.level, e.clip, shade_rsp.shade_level, shade_rsp.clipped);
        end
      end
    end
  end

  // result side backpressure, with one long hold-off in phase 2
  always @(posedge clk) begin
    if (rst) begin
      shade_rsp.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (phase_no == 2 && !hold_done) begin
      shade_rsp.ready <= 1'b0;
      hold_left <= hold_left + 1;
      if (hold_left == HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      shade_rsp.ready <= !(rcv_idle_pct > 0 && $urandom_range(99) < rcv_idle_pct);
    end
  end

  // stimulus
  initial begin
    req_t r;
    shade_t none;
    row_t w;
    none = '{default: '0};
    mismatches = 0; shades_seen = 0; writes_sent = 0; clipped_seen = 0;
    snd_idle_pct = 0; rcv_idle_pct = 0; phase_no = -1;
    eye[0] = 0; eye[1] = 0; eye[2] = 768;
    lamps_used = 0; ambient = 12800;
    rst = 1'b1;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    shade_req.valid = 1'b0; shade_req.cmd = 1'b0; shade_req.light_slot = '0;
    shade_req.lamp_x = '0; shade_req.lamp_y = '0; shade_req.lamp_z = '0;
    shade_req.lamp_power = '0; shade_req.point_x = '0; shade_req.point_y = '0;
    shade_req.point_z = '0; shade_req.normal_x = '0; shade_req.normal_y = '0;
    shade_req.normal_z = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: no lights after reset, so only ambient
    add_shade(0, 0, 0, 0, 0, 16384, 1, 12800, 0);
    add_shade(-32768, 32767, -32768, 32767, -32768, 32767, 1, 12800, 0);
    // fill every slot before any shade reads the table
    add_write(0, 0, 0, 1024, 1000);
    add_write(1, -32768, -32768, -32768, 65535);
    add_write(2, 32767, 32767, 32767, 0);
    add_write(3, 0, 0, 0, 65535);
    add_write(4, 512, -256, 768, 300);
    add_write(5, -1024, 512, 256, 12345);
    add_write(6, 256, 256, -512, 40000);
    add_write(7, 0, 1024, 0, 1);
    // all lights, count beyond the table, top ambient
    add_cfg(CFG_LIGHTS_IN_USE, 15);
    add_cfg(CFG_AMBIENT_LEVEL, 65535);
    add_shade(0, 0, 0, 0, 0, 16384, 0, 0, 0);
    add_shade(0, 0, 0, -16384, 0, 0, 0, 0, 0);
    add_shade(100, -200, 300, 32767, 32767, 32767, 0, 0, 0);
    add_shade(-100, 50, -20, -32768, -32768, -32768, 0, 0, 0);
    // viewer at the point
    add_cfg(CFG_VIEW_X, 0);
    add_cfg(CFG_VIEW_Y, 0);
    add_cfg(CFG_VIEW_Z, 0);
    add_shade(0, 0, 0, 0, 0, 16384, 0, 0, 0);
    // light and view opposite for slot 0
    add_cfg(CFG_LIGHTS_IN_USE, 1);
    add_cfg(CFG_VIEW_Z, -768);
    add_shade(0, 0, 0, 0, 0, 16384, 0, 0, 0);
    // a light almost on the point saturates the sum
    add_write(0, 0, 0, 1, 65535);
    add_shade(0, 0, 0, 0, 0, 16384, 1, 24'hFF_FFFF, 1);
    // nothing at all
    add_cfg(CFG_LIGHTS_IN_USE, 0);
    add_cfg(CFG_AMBIENT_LEVEL, 0);
    add_shade(32767, 32767, 32767, 16384, 0, 0, 1, 0, 0);

    foreach (dir_rows[i]) begin
      w = dir_rows[i];
      if (w.kind == ROW_CFG) begin
        drain();
        write_reg(w.idx, w.val);
        cfg_we <= 1'b0;
      end else begin
        send(w.req, w.has_exp, w.exp_shade);
      end
    end

    // random phases with changing registers and idling
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      phase_no = ph;
      snd_idle_pct = (ph < 2) ? 20 : (ph < 4) ? 78 : 0;
      rcv_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 20 : 0;
      write_reg(CFG_VIEW_X, ph == 0 ? 16'h8000 : pick_coord());
      write_reg(CFG_VIEW_Y, ph == 0 ? 16'h7FFF : pick_coord());
      write_reg(CFG_VIEW_Z, pick_coord());
      write_reg(CFG_LIGHTS_IN_USE,
                ph == 0 ? 16'd8 : ph == 1 ? 16'd15 : 16'($urandom_range(3)));
      write_reg(CFG_AMBIENT_LEVEL, ph == 0 ? 16'hFFFF : ph == 1 ? 16'h0 : 16'($urandom));
      cfg_we <= 1'b0;
      for (int i = 0; i < 125; i++) begin
        r = '{default: '0};
        r.cmd = ($urandom_range(9) < 6) ? CMD_SHADE : CMD_WRITE;
        r.slot = SLOT_W'($urandom);
        r.lx = pick_coord(); r.ly = pick_coord(); r.lz = pick_coord();
        r.pw = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(255));
        r.px = pick_coord(); r.py = pick_coord(); r.pz = pick_coord();
        r.nx = pick_normal(); r.ny = pick_normal(); r.nz = pick_normal();
        send(r, 1'b0, none);
      end
    end

    drain();
    $display("covered %0d light writes and %0d shade results (%0d clipped) over six phases",
             writes_sent, shades_seen, clipped_seen);
    if (mismatches == 0 && shade_expected_q.size() == 0) begin
      $display("blinn_phong_point_shader: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("blinn_phong_point_shader: mismatch");
    end
    $finish;
  end

endmodule
